### design/adm_pkg.sv
// Shared constants, codes and types for the arcade drive mixer.
package adm_pkg;

    localparam int unsigned FIELD_W    = 16;
    localparam int unsigned CFG_W      = 15;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned MUL_W      = 32;
    localparam int unsigned DIV_NUM_W  = 29;
    localparam int unsigned DIV_DEN_W  = 16;
    localparam int unsigned DIV_CNT_W  = $clog2(DIV_NUM_W);

    localparam logic [CFG_W-1:0] RST_DEADBAND       = 15'd1638;
    localparam logic [CFG_W-1:0] RST_SENSE_CUTOFF   = 15'd1638;
    localparam logic [CFG_W-1:0] RST_WIDE_TURN      = 15'd10650;
    localparam logic [CFG_W-1:0] RST_GAIN_HIGH      = 15'd2560;
    localparam logic [CFG_W-1:0] RST_GAIN_TOWARD    = 15'd1280;
    localparam logic [CFG_W-1:0] RST_GAIN_BACK_WIDE = 15'd20480;
    localparam logic [CFG_W-1:0] RST_GAIN_BACK      = 15'd768;
    localparam logic [CFG_W-1:0] RST_SENS_LOW       = 15'd18022;

    localparam logic signed [29:0] HIGH_GEAR_SENS = 30'sd19661;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEADBAND       = 3'd0,
        CFG_SENSE_CUTOFF   = 3'd1,
        CFG_WIDE_TURN      = 3'd2,
        CFG_GAIN_HIGH      = 3'd3,
        CFG_GAIN_TOWARD    = 3'd4,
        CFG_GAIN_BACK_WIDE = 3'd5,
        CFG_GAIN_BACK      = 3'd6,
        CFG_SENS_LOW       = 3'd7
    } t_cfg_idx;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DEAD,
        ST_MULG,
        ST_BOOST,
        ST_MULT,
        ST_ROUND1,
        ST_SENS,
        ST_MULS,
        ST_ROUND2,
        ST_SUM,
        ST_LIM
    } t_state;

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] dividend;
        logic [DIV_DEN_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic                 busy;
        logic [DIV_NUM_W-1:0] quotient;
    } t_div_rsp;

endpackage

### design/adm_if.sv
// Handshake channels of the arcade drive mixer: input word, output word, register writes.
interface adm_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [adm_pkg::FIELD_W-1:0]  throttle;
    logic signed [adm_pkg::FIELD_W-1:0]  wheel;
    logic                                high_gear;
    logic                                quick_turn;

    modport source (output valid, throttle, wheel, high_gear, quick_turn, input ready);
    modport sink   (input valid, throttle, wheel, high_gear, quick_turn, output ready);
endinterface

interface adm_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [adm_pkg::FIELD_W-1:0]  left_drive;
    logic signed [adm_pkg::FIELD_W-1:0]  right_drive;
    logic                                clamped;

    modport source (output valid, left_drive, right_drive, clamped, input ready);
    modport sink   (input valid, left_drive, right_drive, clamped, output ready);
endinterface

interface adm_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [adm_pkg::CFG_IDX_W-1:0]   index;
    logic [adm_pkg::CFG_W-1:0]       data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### design/adm_mul.sv
// Shared signed multiplier with registered product.
module adm_mul (
    input  logic                                  i_clk,
    input  logic                                  i_en,
    input  logic signed [adm_pkg::MUL_W-1:0]      i_a,
    input  logic signed [adm_pkg::MUL_W-1:0]      i_b,
    output logic signed [2*adm_pkg::MUL_W-1:0]    o_prod
);

    logic signed [2*adm_pkg::MUL_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= i_a * i_b;
        end
    end

    assign o_prod = r_prod;

endmodule

### design/adm_div.sv
// Restoring serial divider, one quotient bit per cycle.
module adm_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  adm_pkg::t_div_req i_req,
    output adm_pkg::t_div_rsp o_rsp
);

    logic                              r_busy;
    logic [adm_pkg::DIV_CNT_W-1:0]     r_cnt;
    logic [adm_pkg::DIV_DEN_W-1:0]     r_rem;
    logic [adm_pkg::DIV_DEN_W-1:0]     r_dvs;
    logic [adm_pkg::DIV_NUM_W-1:0]     r_quo;
    logic [adm_pkg::DIV_DEN_W:0]       trial;
    logic [adm_pkg::DIV_DEN_W:0]       diff;
    logic                              fit;

    always_comb begin
        trial = {r_rem, r_quo[adm_pkg::DIV_NUM_W-1]};
        diff  = trial - {1'b0, r_dvs};
        fit   = (trial >= {1'b0, r_dvs});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
        end else if (r_busy && (r_cnt == '0)) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_dvs <= i_req.divisor;
            r_quo <= i_req.dividend;
            r_cnt <= adm_pkg::DIV_CNT_W'(adm_pkg::DIV_NUM_W - 1);
        end else if (r_busy) begin
            r_rem <= fit ? diff[adm_pkg::DIV_DEN_W-1:0] : trial[adm_pkg::DIV_DEN_W-1:0];
            r_quo <= {r_quo[adm_pkg::DIV_NUM_W-2:0], fit};
            r_cnt <= r_cnt - 1'b1;
        end
    end

    assign o_rsp.busy     = r_busy;
    assign o_rsp.quotient = r_quo;

endmodule

### design/arcade_drive_mixer_neg_inertia.sv
// Arcade drive mixer with deadband and negative inertia, one shared multiplier and divider.
// Quick turn takes a shorter path to output valid than other words, and low gear, when it
// rescales sensitivity, waits for the serial divide.
// One word at a time; i_in.ready returns with output valid, so a word waits for the
// previous result. A result still unread when the next one is due stalls the sequencer.
// Synchronous active-low reset: registers to defaults, last wheel to zero, output empty.
module arcade_drive_mixer_neg_inertia (
    input  logic         i_clk,
    input  logic         i_rst_n,
    adm_in_if.sink       i_in,
    adm_out_if.source    o_out,
    adm_cfg_if.sink      i_cfg
);

    localparam logic signed [41:0] LIM_HI = 42'sd16384;
    localparam logic signed [41:0] LIM_LO = -42'sd16384;

    function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] v,
                                                     input int unsigned sh);
        logic [63:0] m;
        m = v[63] ? 64'(-v) : 64'(v);
        m = (m + (64'd1 << (sh - 1))) >> sh;
        return v[63] ? -$signed(m) : $signed(m);
    endfunction

    adm_pkg::t_state r_state, n_state;

    logic [adm_pkg::CFG_W-1:0] r_deadband, r_sense_cutoff, r_wide_turn, r_gain_high;
    logic [adm_pkg::CFG_W-1:0] r_gain_toward, r_gain_back_wide, r_gain_back, r_sens_low;

    logic signed [15:0] r_thr, n_thr, r_whl, n_whl, r_last, n_last, r_w, n_w;
    logic               r_high, n_high, r_quick, n_quick, r_nneg, n_nneg;
    logic               r_use_div, n_use_div;
    logic signed [16:0] r_d, n_d;
    logic [14:0]        r_g, n_g;
    logic [15:0]        r_at, n_at;
    logic signed [24:0] r_b, n_b;
    logic signed [25:0] r_r1, n_r1;
    logic signed [29:0] r_s, n_s;
    logic signed [40:0] r_a, n_a;
    logic signed [41:0] r_left, n_left, r_right, n_right;

    logic               r_ov, n_ov, r_clamp, n_clamp;
    logic signed [15:0] r_lout, n_lout, r_rout, n_rout;

    logic                       mul_en;
    logic signed [31:0]         mul_a, mul_b;
    logic signed [63:0]         prod;
    adm_pkg::t_div_req          div_req;
    adm_pkg::t_div_rsp          div_rsp;

    logic [15:0]        thr_mag, whl_mag, wdb_mag;
    logic signed [15:0] w_db;
    logic signed [16:0] d_new, sdiff;
    logic [14:0]        sdiff_mag;
    logic signed [63:0] b_full, rnd_val;
    logic signed [29:0] q_s, s_div;
    logic signed [41:0] lim_l, lim_r;
    logic               flag;

    adm_mul u_mul (
        .i_clk  (i_clk),
        .i_en   (mul_en),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    adm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // Register writes
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deadband       <= adm_pkg::RST_DEADBAND;
            r_sense_cutoff   <= adm_pkg::RST_SENSE_CUTOFF;
            r_wide_turn      <= adm_pkg::RST_WIDE_TURN;
            r_gain_high      <= adm_pkg::RST_GAIN_HIGH;
            r_gain_toward    <= adm_pkg::RST_GAIN_TOWARD;
            r_gain_back_wide <= adm_pkg::RST_GAIN_BACK_WIDE;
            r_gain_back      <= adm_pkg::RST_GAIN_BACK;
            r_sens_low       <= adm_pkg::RST_SENS_LOW;
        end else if (i_cfg.valid) begin
            unique case (adm_pkg::t_cfg_idx'(i_cfg.index))
                adm_pkg::CFG_DEADBAND:       r_deadband       <= i_cfg.data;
                adm_pkg::CFG_SENSE_CUTOFF:   r_sense_cutoff   <= i_cfg.data;
                adm_pkg::CFG_WIDE_TURN:      r_wide_turn      <= i_cfg.data;
                adm_pkg::CFG_GAIN_HIGH:      r_gain_high      <= i_cfg.data;
                adm_pkg::CFG_GAIN_TOWARD:    r_gain_toward    <= i_cfg.data;
                adm_pkg::CFG_GAIN_BACK_WIDE: r_gain_back_wide <= i_cfg.data;
                adm_pkg::CFG_GAIN_BACK:      r_gain_back      <= i_cfg.data;
                adm_pkg::CFG_SENS_LOW:       r_sens_low       <= i_cfg.data;
            endcase
        end
    end

    // Deadband, difference and divider operands
    always_comb begin
        thr_mag   = r_thr[15] ? (16'd0 - r_thr) : r_thr;
        whl_mag   = r_whl[15] ? (16'd0 - r_whl) : r_whl;
        w_db      = (whl_mag < {1'b0, r_deadband}) ? 16'sd0 : r_whl;
        wdb_mag   = (whl_mag < {1'b0, r_deadband}) ? 16'd0 : whl_mag;
        d_new     = {w_db[15], w_db} - {r_last[15], r_last};
        sdiff     = 17'sd16384 - $signed({2'b00, r_sens_low});
        sdiff_mag = sdiff[16] ? 15'(-sdiff) : 15'(sdiff);
        q_s       = r_nneg ? -$signed({1'b0, div_rsp.quotient})
                           : $signed({1'b0, div_rsp.quotient});
        s_div     = 30'sd16384 - q_s;
    end

    // Limit chain, then clamp of both sides
    always_comb begin
        lim_l = r_left;
        lim_r = r_right;
        flag  = (r_left > LIM_HI) || (r_left < LIM_LO) ||
                (r_right > LIM_HI) || (r_right < LIM_LO);
        priority if (lim_l > LIM_HI) begin
            if (r_quick) lim_r = lim_r - (lim_l - LIM_HI);
            lim_l = LIM_HI;
        end else if (lim_r > LIM_HI) begin
            if (r_quick) lim_l = lim_l - (lim_r - LIM_HI);
            lim_r = LIM_HI;
        end else if (lim_l < LIM_LO) begin
            if (r_quick) lim_r = lim_r + (LIM_LO - lim_l);
            lim_l = LIM_LO;
        end else if (lim_r < LIM_LO) begin
            if (r_quick) lim_l = lim_l + (LIM_LO - lim_r);
            lim_r = LIM_LO;
        end else begin
            // both sides in range
        end
        if (lim_l > LIM_HI) lim_l = LIM_HI;
        if (lim_l < LIM_LO) lim_l = LIM_LO;
        if (lim_r > LIM_HI) lim_r = LIM_HI;
        if (lim_r < LIM_LO) lim_r = LIM_LO;
    end

    // Sequencer
    always_comb begin
        n_state   = r_state;
        n_thr     = r_thr;
        n_whl     = r_whl;
        n_high    = r_high;
        n_quick   = r_quick;
        n_last    = r_last;
        n_w       = r_w;
        n_d       = r_d;
        n_g       = r_g;
        n_at      = r_at;
        n_nneg    = r_nneg;
        n_use_div = r_use_div;
        n_b       = r_b;
        n_r1      = r_r1;
        n_s       = r_s;
        n_a       = r_a;
        n_left    = r_left;
        n_right   = r_right;
        n_lout    = r_lout;
        n_rout    = r_rout;
        n_clamp   = r_clamp;
        n_ov      = r_ov && !o_out.ready;

        mul_en           = 1'b0;
        mul_a            = '0;
        mul_b            = '0;
        div_req.start    = 1'b0;
        div_req.dividend = {sdiff_mag, 14'd0};
        div_req.divisor  = thr_mag;
        i_in.ready       = (r_state == adm_pkg::ST_IDLE);
        rnd_val          = '0;
        b_full           = '0;

        unique case (r_state)
            adm_pkg::ST_IDLE: begin
                if (i_in.valid) begin
                    n_thr   = i_in.throttle;
                    n_whl   = i_in.wheel;
                    n_high  = i_in.high_gear;
                    n_quick = i_in.quick_turn;
                    n_state = adm_pkg::ST_DEAD;
                end
            end
            adm_pkg::ST_DEAD: begin
                n_w    = w_db;
                n_last = w_db;
                n_d    = d_new;
                n_at   = thr_mag;
                n_nneg = sdiff[16];
                if (r_high) begin
                    n_g = r_gain_high;
                end else if ((w_db > 16'sd0 && d_new > 17'sd0) ||
                             (w_db < 16'sd0 && d_new < 17'sd0)) begin
                    n_g = r_gain_toward;
                end else if (wdb_mag > {1'b0, r_wide_turn}) begin
                    n_g = r_gain_back_wide;
                end else begin
                    n_g = r_gain_back;
                end
                n_use_div     = !r_high && !r_quick && (thr_mag > {1'b0, r_sense_cutoff});
                div_req.start = n_use_div;
                n_state       = adm_pkg::ST_MULG;
            end
            adm_pkg::ST_MULG: begin
                mul_en  = 1'b1;
                mul_a   = {{15{r_d[16]}}, r_d};
                mul_b   = {17'd0, r_g};
                n_state = adm_pkg::ST_BOOST;
            end
            adm_pkg::ST_BOOST: begin
                rnd_val = rnd_shift(prod, 8);
                b_full  = {{48{r_w[15]}}, r_w} + rnd_val;
                n_b     = b_full[24:0];
                if (r_quick) begin
                    n_a     = {{16{b_full[24]}}, b_full[24:0]};
                    n_state = adm_pkg::ST_SUM;
                end else begin
                    n_state = adm_pkg::ST_MULT;
                end
            end
            adm_pkg::ST_MULT: begin
                mul_en  = 1'b1;
                mul_a   = {16'd0, r_at};
                mul_b   = {{7{r_b[24]}}, r_b};
                n_state = adm_pkg::ST_ROUND1;
            end
            adm_pkg::ST_ROUND1: begin
                rnd_val = rnd_shift(prod, 14);
                n_r1    = rnd_val[25:0];
                n_state = adm_pkg::ST_SENS;
            end
            adm_pkg::ST_SENS: begin
                if (!div_rsp.busy) begin
                    if (r_high) begin
                        n_s = adm_pkg::HIGH_GEAR_SENS;
                    end else if (r_use_div) begin
                        n_s = s_div;
                    end else begin
                        n_s = $signed({15'd0, r_sens_low});
                    end
                    n_state = adm_pkg::ST_MULS;
                end
            end
            adm_pkg::ST_MULS: begin
                mul_en  = 1'b1;
                mul_a   = {{6{r_r1[25]}}, r_r1};
                mul_b   = {{2{r_s[29]}}, r_s};
                n_state = adm_pkg::ST_ROUND2;
            end
            adm_pkg::ST_ROUND2: begin
                rnd_val = rnd_shift(prod, 14);
                n_a     = rnd_val[40:0];
                n_state = adm_pkg::ST_SUM;
            end
            adm_pkg::ST_SUM: begin
                n_left  = $signed({{26{r_thr[15]}}, r_thr}) + $signed({r_a[40], r_a});
                n_right = $signed({{26{r_thr[15]}}, r_thr}) - $signed({r_a[40], r_a});
                n_state = adm_pkg::ST_LIM;
            end
            adm_pkg::ST_LIM: begin
                if (!r_ov || o_out.ready) begin
                    n_lout  = lim_l[15:0];
                    n_rout  = lim_r[15:0];
                    n_clamp = flag;
                    n_ov    = 1'b1;
                    n_state = adm_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = adm_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= adm_pkg::ST_IDLE;
            r_ov    <= 1'b0;
            r_last  <= '0;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
            r_last  <= n_last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_thr     <= n_thr;
        r_whl     <= n_whl;
        r_high    <= n_high;
        r_quick   <= n_quick;
        r_w       <= n_w;
        r_d       <= n_d;
        r_g       <= n_g;
        r_at      <= n_at;
        r_nneg    <= n_nneg;
        r_use_div <= n_use_div;
        r_b       <= n_b;
        r_r1      <= n_r1;
        r_s       <= n_s;
        r_a       <= n_a;
        r_left    <= n_left;
        r_right   <= n_right;
        r_lout    <= n_lout;
        r_rout    <= n_rout;
        r_clamp   <= n_clamp;
    end

    assign o_out.valid       = r_ov;
    assign o_out.left_drive  = r_lout;
    assign o_out.right_drive = r_rout;
    assign o_out.clamped     = r_clamp;

endmodule
